>>> design/sti_pkg.sv
// Package for the segment/triangle intersection pipeline: item record,
// stage map and the per-stage datapath function. No dependencies.
package sti_pkg;

  localparam int unsigned CW       = 16;          // coordinate width
  localparam int unsigned IN_W     = 5 * 3 * CW;  // input tdata width
  localparam int unsigned OUT_W    = 3 * CW;      // output tdata width

  // stage map
  localparam int unsigned ST_SQ0   = 8;           // first square-root step
  localparam int unsigned SQ_STEPS = 31;
  localparam int unsigned ST_LEN   = ST_SQ0 + SQ_STEPS;
  localparam int unsigned ST_DV0   = ST_LEN + 1;  // normal divide steps
  localparam int unsigned DV_STEPS = 15;
  localparam int unsigned ST_N     = ST_DV0 + DV_STEPS;
  localparam int unsigned ST_DP    = ST_N + 1;
  localparam int unsigned ST_DSUM  = ST_DP + 1;
  localparam int unsigned ST_SIDE  = ST_DSUM + 1;
  localparam int unsigned ST_PP    = ST_SIDE + 1;
  localparam int unsigned ST_XNUM  = ST_PP + 1;
  localparam int unsigned ST_XD0   = ST_XNUM + 1; // crossing divide steps
  localparam int unsigned XD_STEPS = 16;
  localparam int unsigned ST_X     = ST_XD0 + XD_STEPS;
  localparam int unsigned ST_XV    = ST_X + 1;
  localparam int unsigned ST_EP    = ST_XV + 1;
  localparam int unsigned ST_EC    = ST_EP + 1;
  localparam int unsigned ST_ED    = ST_EC + 1;
  localparam int unsigned ST_EIN   = ST_ED + 1;
  localparam int unsigned ST_PU    = ST_EIN + 1;
  localparam int unsigned NUM_ST   = ST_PU + 1;   // last stage drives the output

  // cyclic component neighbors for cross products
  localparam int unsigned NXT1 [3] = '{1, 2, 0};
  localparam int unsigned NXT2 [3] = '{2, 0, 1};

  typedef struct packed {
    logic [2:0][15:0]      a, b, c, s, e;
    logic [2:0][16:0]      ab, ac, bc, ca, sa, ea, es;
    logic [5:0][33:0]      pr;
    logic [2:0][34:0]      nc;
    logic                  miss;
    logic [2:0]            neg;
    logic [2:0][32:0]      mg;
    logic [2:0][29:0]      ncs;
    logic [2:0][59:0]      sq;
    logic [61:0]           rad;
    logic [61:0]           root;
    logic [30:0]           len;
    logic [2:0][45:0]      dnum;
    logic [2:0][14:0]      q;
    logic [2:0][15:0]      n;
    logic [5:0][32:0]      dp;
    logic [34:0]           ds, de;
    logic [31:0]           dd;
    logic [32:0]           ssum;
    logic [32:0]           back;
    logic [2:0]            esn;
    logic [2:0][15:0]      esm;
    logic [2:0][1:0][31:0] pp;
    logic [2:0][48:0]      xnum;
    logic [2:0][15:0]      xq;
    logic [2:0][16:0]      x;
    logic [2:0][17:0]      xa, xb, xc;
    logic [2:0][5:0][34:0] ep;
    logic [2:0][2:0][35:0] ec;
    logic [2:0][2:0][51:0] ed;
    logic [2:0]            ein;
    logic [2:0][48:0]      pu;
    logic                  hit;
    logic [2:0][15:0]      push;
  } item_t;

  // x sits in the high bits of each packed vertex
  function automatic item_t unpack_item(input logic [IN_W-1:0] d);
    item_t o;
    o = '0;
    for (int unsigned i = 0; i < 3; i++) begin
      o.a[i] = d[0*48 + (2-i)*CW +: CW];
      o.b[i] = d[1*48 + (2-i)*CW +: CW];
      o.c[i] = d[2*48 + (2-i)*CW +: CW];
      o.s[i] = d[3*48 + (2-i)*CW +: CW];
      o.e[i] = d[4*48 + (2-i)*CW +: CW];
    end
    return o;
  endfunction

  function automatic item_t pipe_step(input int unsigned idx, input item_t it);
    item_t o;
    int unsigned j;
    logic [61:0] bitv;
    logic [62:0] t;
    logic [45:0] dden;
    logic [48:0] xden;
    logic [34:0] tnc, dsm, dem;
    logic [32:0] orv;
    logic [1:0] kk;
    logic [15:0] tq;
    logic [16:0] xs;
    logic [2:0][16:0] uu;
    logic [2:0][17:0] ww;
    logic [53:0] esum;
    logic [48:0] pm;
    logic [20:0] pq;
    o = it;
    bitv = '0; t = '0; dden = '0; xden = '0; tnc = '0; dsm = '0; dem = '0;
    orv = '0; kk = '0; tq = '0; xs = '0; uu = '0; ww = '0; esum = '0;
    pm = '0; pq = '0; j = 0;
    if (idx == 1) begin
      for (int unsigned i = 0; i < 3; i++) begin
        o.ab[i] = 17'($signed(it.b[i])) - 17'($signed(it.a[i]));
        o.ac[i] = 17'($signed(it.c[i])) - 17'($signed(it.a[i]));
        o.bc[i] = 17'($signed(it.c[i])) - 17'($signed(it.b[i]));
        o.ca[i] = 17'($signed(it.a[i])) - 17'($signed(it.c[i]));
        o.sa[i] = 17'($signed(it.s[i])) - 17'($signed(it.a[i]));
        o.ea[i] = 17'($signed(it.e[i])) - 17'($signed(it.a[i]));
        o.es[i] = 17'($signed(it.e[i])) - 17'($signed(it.s[i]));
      end
    end else if (idx == 2) begin
      for (int unsigned i = 0; i < 3; i++) begin
        o.pr[2*i]   = 34'($signed(it.ab[NXT1[i]])) * 34'($signed(it.ac[NXT2[i]]));
        o.pr[2*i+1] = 34'($signed(it.ab[NXT2[i]])) * 34'($signed(it.ac[NXT1[i]]));
      end
    end else if (idx == 3) begin
      for (int unsigned i = 0; i < 3; i++) begin
        o.nc[i] = 35'($signed(it.pr[2*i])) - 35'($signed(it.pr[2*i+1]));
      end
      o.miss = (o.nc == '0);
    end else if (idx == 4) begin
      for (int unsigned i = 0; i < 3; i++) begin
        o.neg[i] = it.nc[i][34];
        tnc = it.nc[i][34] ? -it.nc[i] : it.nc[i];
        o.mg[i] = tnc[32:0];
      end
    end else if (idx == 5) begin
      // shift so the largest magnitude drops below 2^30
      orv = it.mg[0] | it.mg[1] | it.mg[2];
      kk = orv[32] ? 2'd3 : orv[31] ? 2'd2 : orv[30] ? 2'd1 : 2'd0;
      for (int unsigned i = 0; i < 3; i++) begin
        o.ncs[i] = 30'(it.mg[i] >> kk);
      end
    end else if (idx == 6) begin
      for (int unsigned i = 0; i < 3; i++) begin
        o.sq[i] = 60'(it.ncs[i]) * 60'(it.ncs[i]);
      end
    end else if (idx == 7) begin
      o.rad = 62'(it.sq[0]) + 62'(it.sq[1]) + 62'(it.sq[2]);
      o.root = '0;
    end else if (idx >= ST_SQ0 && idx < ST_LEN) begin
      j = idx - ST_SQ0;
      bitv = 62'(1) << (2 * (30 - j));
      t = 63'(it.root) + 63'(bitv);
      if (63'(it.rad) >= t) begin
        o.rad = it.rad - t[61:0];
        o.root = (it.root >> 1) + bitv;
      end else begin
        o.root = it.root >> 1;
      end
    end else if (idx == ST_LEN) begin
      o.len = it.root[30:0];
      for (int unsigned i = 0; i < 3; i++) begin
        o.dnum[i] = (46'(it.ncs[i]) << 14) + 46'(it.root[30:1]);
        o.q[i] = '0;
      end
    end else if (idx >= ST_DV0 && idx < ST_N) begin
      j = 14 - (idx - ST_DV0);
      dden = 46'(it.len) << j;
      for (int unsigned i = 0; i < 3; i++) begin
        if (it.dnum[i] >= dden) begin
          o.dnum[i] = it.dnum[i] - dden;
          o.q[i][j] = 1'b1;
        end
      end
    end else if (idx == ST_N) begin
      for (int unsigned i = 0; i < 3; i++) begin
        tq = 16'(it.q[i]);
        o.n[i] = it.neg[i] ? -tq : tq;
      end
    end else if (idx == ST_DP) begin
      for (int unsigned i = 0; i < 3; i++) begin
        o.dp[i]   = 33'($signed(it.sa[i])) * 33'($signed(it.n[i]));
        o.dp[3+i] = 33'($signed(it.ea[i])) * 33'($signed(it.n[i]));
      end
    end else if (idx == ST_DSUM) begin
      o.ds = 35'($signed(it.dp[0])) + 35'($signed(it.dp[1])) + 35'($signed(it.dp[2]));
      o.de = 35'($signed(it.dp[3])) + 35'($signed(it.dp[4])) + 35'($signed(it.dp[5]));
    end else if (idx == ST_SIDE) begin
      // touching the plane or staying on one side is a miss
      o.miss = it.miss || (it.ds == '0) || (it.de == '0) || (it.ds[34] == it.de[34]);
      dsm = it.ds[34] ? -it.ds : it.ds;
      dem = it.de[34] ? -it.de : it.de;
      o.dd = dsm[31:0];
      o.ssum = 33'(dsm[31:0]) + 33'(dem[31:0]);
      o.back = it.ds[34] ? dsm[32:0] : dem[32:0];
      for (int unsigned i = 0; i < 3; i++) begin
        o.esn[i] = it.es[i][16];
        xs = it.es[i][16] ? -it.es[i] : it.es[i];
        o.esm[i] = xs[15:0];
      end
    end else if (idx == ST_PP) begin
      for (int unsigned i = 0; i < 3; i++) begin
        o.pp[i][1] = 32'(it.esm[i]) * 32'(it.dd[31:16]);
        o.pp[i][0] = 32'(it.esm[i]) * 32'(it.dd[15:0]);
      end
    end else if (idx == ST_XNUM) begin
      for (int unsigned i = 0; i < 3; i++) begin
        o.xnum[i] = (49'(it.pp[i][1]) << 16) + 49'(it.pp[i][0]) + 49'(it.ssum[32:1]);
        o.xq[i] = '0;
      end
    end else if (idx >= ST_XD0 && idx < ST_X) begin
      j = 15 - (idx - ST_XD0);
      xden = 49'(it.ssum) << j;
      for (int unsigned i = 0; i < 3; i++) begin
        if (it.xnum[i] >= xden) begin
          o.xnum[i] = it.xnum[i] - xden;
          o.xq[i][j] = 1'b1;
        end
      end
    end else if (idx == ST_X) begin
      for (int unsigned i = 0; i < 3; i++) begin
        xs = 17'(it.xq[i]);
        o.x[i] = 17'($signed(it.s[i])) + (it.esn[i] ? -xs : xs);
      end
    end else if (idx == ST_XV) begin
      for (int unsigned i = 0; i < 3; i++) begin
        o.xa[i] = 18'($signed(it.x[i])) - 18'($signed(it.a[i]));
        o.xb[i] = 18'($signed(it.x[i])) - 18'($signed(it.b[i]));
        o.xc[i] = 18'($signed(it.x[i])) - 18'($signed(it.c[i]));
      end
    end else if (idx == ST_EP) begin
      for (int unsigned g = 0; g < 3; g++) begin
        case (g)
          0: begin uu = it.ab; ww = it.xa; end
          1: begin uu = it.bc; ww = it.xb; end
          default: begin uu = it.ca; ww = it.xc; end
        endcase
        for (int unsigned i = 0; i < 3; i++) begin
          o.ep[g][2*i]   = 35'($signed(uu[NXT1[i]])) * 35'($signed(ww[NXT2[i]]));
          o.ep[g][2*i+1] = 35'($signed(uu[NXT2[i]])) * 35'($signed(ww[NXT1[i]]));
        end
      end
    end else if (idx == ST_EC) begin
      for (int unsigned g = 0; g < 3; g++) begin
        for (int unsigned i = 0; i < 3; i++) begin
          o.ec[g][i] = 36'($signed(it.ep[g][2*i])) - 36'($signed(it.ep[g][2*i+1]));
        end
      end
    end else if (idx == ST_ED) begin
      for (int unsigned g = 0; g < 3; g++) begin
        for (int unsigned i = 0; i < 3; i++) begin
          o.ed[g][i] = 52'($signed(it.ec[g][i])) * 52'($signed(it.n[i]));
        end
      end
    end else if (idx == ST_EIN) begin
      // an edge value of zero counts as inside
      for (int unsigned g = 0; g < 3; g++) begin
        esum = 54'($signed(it.ed[g][0])) + 54'($signed(it.ed[g][1]))
             + 54'($signed(it.ed[g][2]));
        o.ein[g] = !esum[53];
      end
    end else if (idx == ST_PU) begin
      o.hit = !it.miss && (&it.ein);
      for (int unsigned i = 0; i < 3; i++) begin
        o.pu[i] = 49'($signed(it.n[i])) * 49'($signed(it.back));
      end
    end else if (idx == NUM_ST) begin
      for (int unsigned i = 0; i < 3; i++) begin
        pm = it.pu[i][48] ? -it.pu[i] : it.pu[i];
        pq = 21'((pm + 49'(1 << 27)) >> 28);
        if (!it.hit) begin
          o.push[i] = '0;
        end else if (it.pu[i][48]) begin
          o.push[i] = (pq > 21'd32768) ? 16'h8000 : 16'(-pq);
        end else begin
          o.push[i] = (pq > 21'd32767) ? 16'h7fff : pq[15:0];
        end
      end
    end
    return o;
  endfunction

endpackage

>>> design/segment_triangle_intersect.sv
// Segment/triangle intersection: pipelined top level with stream ports.
// Depends on sti_pkg for the item record and the per-stage datapath.

// One test enters per clock unless the output stalls; each result leaves from
// stage NUM_ST, a depth set by the 31-step square root of the normal
// length and the 15- and 16-step restoring dividers for the unit normal and
// the crossing point, each step one register stage. A stall on the output
// holds the whole pipeline in place, so nothing is dropped or repeated.
// Coordinates are signed Q8.8; a miss returns hit = 0 with a zero vector.
module segment_triangle_intersect (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // from bit 0: tri_vertex_a, tri_vertex_b, tri_vertex_c, seg_start, seg_end
  input  logic [sti_pkg::IN_W-1:0]    s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // from bit 0: push_x, push_y, push_z
  output logic [sti_pkg::OUT_W-1:0]   m_axis_tdata,
  // bit 0: hit
  output logic [0:0]                  m_axis_tuser
);
  import sti_pkg::*;

  item_t       st [0:NUM_ST];
  item_t       nx [1:NUM_ST];
  logic [NUM_ST:0] v;
  logic        en;

  assign en = !v[NUM_ST] || m_axis_tready;
  assign s_axis_tready = en;

  for (genvar g = 1; g <= NUM_ST; g++) begin : g_stage
    assign nx[g] = pipe_step(g, st[g-1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NUM_ST-1:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= unpack_item(s_axis_tdata);
      for (int unsigned g = 1; g <= NUM_ST; g++) begin
        st[g] <= nx[g];
      end
    end
  end

  assign m_axis_tvalid = v[NUM_ST];
  assign m_axis_tdata  = {st[NUM_ST].push[2], st[NUM_ST].push[1], st[NUM_ST].push[0]};
  assign m_axis_tuser  = st[NUM_ST].hit;

  // a miss never carries a push vector
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("push vector nonzero on a miss");

  // a held pipeline keeps its occupancy
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(v))
    else $error("pipeline valid bits moved during a stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> v == '0)
    else $error("pipeline not empty after reset");

endmodule

>>> test/segment_triangle_intersect_tb.sv
// Testbench for segment_triangle_intersect: directed table plus random tests, checked
// against typed values or a behavioral intersection predictor. Uses sti_pkg widths.
`timescale 1ns / 100ps

module segment_triangle_intersect_tb;
  import sti_pkg::*;

  localparam int N_RAND = 1700;
  localparam int DRAIN = 200;

  typedef struct {
    logic hit;
    logic [15:0] px, py, pz;
  } push_t;

  typedef struct {
    logic [47:0] a, b, c, s, e;
    bit known;     // expected value typed in the table
    push_t res;
  } test_row_t;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;

  push_t pending_push[$];
  int errors = 0;
  int src_idle = 0, snk_stall = 0;   // percent

  segment_triangle_intersect dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint div_rnd(longint num, longint den);
    longint q;
    q = (mag(num) + den / 2) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic longint sat(longint v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  function automatic void coords(logic [47:0] w, output longint v[3]);
    for (int i = 0; i < 3; i++) v[i] = longint'($signed(w[(2-i)*16 +: 16]));
  endfunction

  function automatic void cross3(longint u[3], longint w[3], output longint r[3]);
    r[0] = u[1]*w[2] - u[2]*w[1];
    r[1] = u[2]*w[0] - u[0]*w[2];
    r[2] = u[0]*w[1] - u[1]*w[0];
  endfunction

  function automatic longint dot3(longint u[3], longint w[3]);
    return u[0]*w[0] + u[1]*w[1] + u[2]*w[2];
  endfunction

  function automatic longint floor_sqrt(longint v);
    longint r, bitv;
    r = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > v) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v -= r + bitv;
        r = (r >>> 1) + bitv;
      end else r = r >>> 1;
      bitv = bitv >>> 2;
    end
    return r;
  endfunction

  function automatic push_t predict_push(logic [47:0] wa, wb, wc, ws, we);
    push_t o;
    longint a[3], b[3], c[3], s[3], e[3], ab[3], ac[3], nc[3], n[3], x[3];
    longint t1[3], t2[3], t3[3], mx, len, ds, de, dd, sm, back, p;
    int k;
    o = '{0, 0, 0, 0};
    coords(wa, a); coords(wb, b); coords(wc, c); coords(ws, s); coords(we, e);
    for (int i = 0; i < 3; i++) begin
      ab[i] = b[i] - a[i];
      ac[i] = c[i] - a[i];
    end
    cross3(ab, ac, nc);
    if (nc[0] == 0 && nc[1] == 0 && nc[2] == 0) return o;
    mx = 0;
    foreach (nc[i]) if (mag(nc[i]) > mx) mx = mag(nc[i]);
    k = 0;
    while ((mx >> k) >= (64'sd1 << 30)) k++;
    foreach (nc[i]) nc[i] = nc[i] < 0 ? -(mag(nc[i]) >> k) : (nc[i] >> k);
    len = floor_sqrt(dot3(nc, nc));
    if (len == 0) return o;
    foreach (n[i]) n[i] = div_rnd(nc[i] * 16384, len);
    for (int i = 0; i < 3; i++) begin
      t1[i] = s[i] - a[i];
      t2[i] = e[i] - a[i];
    end
    ds = dot3(t1, n);
    de = dot3(t2, n);
    if (ds == 0 || de == 0 || (ds < 0) == (de < 0)) return o;
    dd = mag(ds);
    sm = dd + mag(de);
    foreach (x[i]) x[i] = s[i] + div_rnd((e[i] - s[i]) * dd, sm);
    for (int i = 0; i < 3; i++) t1[i] = x[i] - a[i];
    cross3(ab, t1, t3);
    if (dot3(t3, n) < 0) return o;
    for (int i = 0; i < 3; i++) begin
      t1[i] = c[i] - b[i];
      t2[i] = x[i] - b[i];
    end
    cross3(t1, t2, t3);
    if (dot3(t3, n) < 0) return o;
    for (int i = 0; i < 3; i++) begin
      t1[i] = a[i] - c[i];
      t2[i] = x[i] - c[i];
    end
    cross3(t1, t2, t3);
    if (dot3(t3, n) < 0) return o;
    back = ds < 0 ? -ds : -de;
    o.hit = 1;
    foreach (n[i]) begin
      p = n[i] * back;
      p = (mag(p) + (64'sd1 << 27)) >> 28;
      p = sat(n[i] * back < 0 ? -p : p);
      if (i == 0) o.px = p[15:0];
      else if (i == 1) o.py = p[15:0];
      else o.pz = p[15:0];
    end
    return o;
  endfunction

  function automatic logic [47:0] pt(int x, int y, int z);
    return {x[15:0], y[15:0], z[15:0]};
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic send_item(test_row_t r);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {r.e, r.s, r.c, r.b, r.a};
    pending_push.push_back(r.known ? r.res : predict_push(r.a, r.b, r.c, r.s, r.e));
    do @(posedge clk); while (!s_axis_tready);
  endtask

  function automatic logic [47:0] rnd_pt(int span);
    if (span == 0) return 48'({$urandom, $urandom});
    return pt($urandom_range(2*span) - span, $urandom_range(2*span) - span,
              $urandom_range(2*span) - span);
  endfunction

  // output side: stall and check
  always @(posedge clk) begin
    push_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_push.size() == 0) begin
          $display("unexpected result at %0t", $realtime);
          errors++;
        end else begin
          want = pending_push.pop_front();
          if (m_axis_tuser[0] !== want.hit)
            report_mismatch("hit", 16'(m_axis_tuser), 16'(want.hit));
          if (m_axis_tdata[15:0] !== want.px)
            report_mismatch("push_x", m_axis_tdata[15:0], want.px);
          if (m_axis_tdata[31:16] !== want.py)
            report_mismatch("push_y", m_axis_tdata[31:16], want.py);
          if (m_axis_tdata[47:32] !== want.pz)
            report_mismatch("push_z", m_axis_tdata[47:32], want.pz);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= snk_stall);
    end
  end

  initial begin
    test_row_t dir_tests[$];
    test_row_t r;
    int span;
    push_t miss;
    miss = '{0, 0, 0, 0};
    // triangle in z=0 plane
    dir_tests.push_back('{pt(0,0,0), pt(2560,0,0), pt(0,2560,0),
                          pt(256,256,-256), pt(256,256,256), 0, miss});
    dir_tests.push_back('{pt(0,0,0), pt(2560,0,0), pt(0,2560,0),
                          pt(256,256,256), pt(256,256,-512), 0, miss});
    // degenerate triangle
    dir_tests.push_back('{pt(5,5,5), pt(5,5,5), pt(9,9,9),
                          pt(0,0,-9), pt(0,0,9), 1, miss});
    // endpoint on plane
    dir_tests.push_back('{pt(0,0,0), pt(2560,0,0), pt(0,2560,0),
                          pt(256,256,0), pt(256,256,256), 1, miss});
    // same side
    dir_tests.push_back('{pt(0,0,0), pt(2560,0,0), pt(0,2560,0),
                          pt(256,256,10), pt(256,256,256), 1, miss});
    // outside the triangle
    dir_tests.push_back('{pt(0,0,0), pt(2560,0,0), pt(0,2560,0),
                          pt(2560,2560,-9), pt(2560,2560,9), 0, miss});
    // crossing on an edge and a vertex
    dir_tests.push_back('{pt(0,0,0), pt(2560,0,0), pt(0,2560,0),
                          pt(256,0,-9), pt(256,0,9), 0, miss});
    dir_tests.push_back('{pt(0,0,0), pt(2560,0,0), pt(0,2560,0),
                          pt(0,0,-9), pt(0,0,9), 0, miss});
    // large push, saturating
    dir_tests.push_back('{pt(-32768,-32768,0), pt(32767,-32768,0), pt(0,32767,0),
                          pt(0,0,-32768), pt(0,0,32767), 0, miss});
    dir_tests.push_back('{pt(-32768,-32768,0), pt(32767,-32768,0), pt(0,32767,0),
                          pt(0,0,32767), pt(0,0,-32768), 0, miss});
    // extreme tilted triangle, big cross product
    dir_tests.push_back('{pt(-32768,-32768,-32768), pt(32767,-32768,32767),
                          pt(-32768,32767,32767), pt(32767,32767,-32768),
                          pt(-32768,-32768,32767), 0, miss});
    dir_tests.push_back('{48'hffffffffffff, 48'h0, 48'h800080008000,
                          48'h7fff7fff7fff, 48'h800080008000, 0, miss});
    dir_tests.push_back('{48'h0, 48'h0, 48'h0, 48'h0, 48'h0, 1, miss});
    repeat (10) @(posedge clk);
    rst <= 0;
    m_axis_tready <= 1;
    foreach (dir_tests[i]) send_item(dir_tests[i]);
    for (int i = 0; i < N_RAND; i++) begin
      case (i / (N_RAND / 4))
        0: begin src_idle = 0; snk_stall = 0; end
        1: begin src_idle = 80; snk_stall = 0; end
        2: begin src_idle = 0; snk_stall = 80; end
        default: begin src_idle = 17; snk_stall = 17; end
      endcase
      if ((i % 200) < 20) begin src_idle = 0; snk_stall = 0; end
      span = ($urandom_range(9) == 0) ? 0 : (1 << $urandom_range(15, 6));
      r.a = rnd_pt(span); r.b = rnd_pt(span); r.c = rnd_pt(span);
      r.known = 0;
      if ($urandom_range(3) != 0) begin
        // segment through a point inside or on an edge of the triangle, across its plane
        int w1, w2, dz;
        longint ca[3], cb[3], cc[3], n[3], u[3], v[3];
        coords(r.a, ca); coords(r.b, cb); coords(r.c, cc);
        w1 = $urandom_range(100); w2 = $urandom_range(100 - w1);
        for (int k = 0; k < 3; k++) begin
          u[k] = cb[k] - ca[k]; v[k] = cc[k] - ca[k];
        end
        cross3(u, v, n);
        mx_scale: begin
          longint m;
          m = mag(n[0]) + mag(n[1]) + mag(n[2]) + 1;
          dz = $urandom_range(4000, 1);
          for (int k = 0; k < 3; k++) begin
            longint p, o1, o2;
            p = ca[k] + (u[k] * w1 + v[k] * w2) / 100;
            o1 = p + n[k] * dz / m;
            o2 = p - n[k] * dz * longint'($urandom_range(3, 1)) / m;
            r.s[(2-k)*16 +: 16] = 16'(sat(o1)); r.e[(2-k)*16 +: 16] = 16'(sat(o2));
          end
        end
      end else begin
        r.s = rnd_pt(span); r.e = rnd_pt(span);
      end
      send_item(r);
    end
    s_axis_tvalid <= 0;
    while (pending_push.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> sim.f
design/sti_pkg.sv
design/segment_triangle_intersect.sv
test/segment_triangle_intersect_tb.sv
